[design/lzwd_pkg.sv]
// Package for the LZSS window decompressor.
// Holds the copy command passed from the parser to the copy engine.
// No dependencies.
`default_nettype none

package lzwd_pkg;

  localparam int unsigned WindowDepth = 4096;
  localparam int unsigned DistW       = 12;
  localparam int unsigned LenW        = 5;
  localparam int unsigned CmdDepth    = 4;
  localparam int unsigned RemW        = 24;
  localparam logic [3:0]  MatchBias   = 4'd3;
  localparam logic [3:0]  GroupTokens = 4'd8;

  typedef struct packed {
    logic             lit;
    logic [7:0]       data;
    logic [DistW-1:0] offset;
    logic [LenW-1:0]  len;
    logic             eod;
  } cmd_t;

endpackage

`default_nettype wire

[design/lzwd_front.sv]
// Stream parser: reads header, flag bytes and tokens, and issues copy commands.
// Depends on lzwd_pkg.
`default_nettype none

module lzwd_front
  import lzwd_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       start_of_stream_i,
  input  wire logic       full_i,
  output logic            push_o,
  output cmd_t            cmd_o
);

  typedef enum logic [2:0] {
    PhIdle, PhHdr1, PhHdr2, PhHdr3, PhFlags, PhToken, PhMatch2
  } phase_e;

  phase_e          phase_q, phase_d;
  logic [RemW-1:0] rem_q, rem_d;
  logic [7:0]      flags_q, flags_d;
  logic [3:0]      tl_q, tl_d;
  logic [7:0]      m1_q, m1_d;

  logic            acc;
  logic [LenW-1:0] mlen;
  logic [LenW-1:0] clen;
  logic [RemW-1:0] rem_tok;
  logic [3:0]      tl_dec;
  logic [RemW-1:0] hdr_len;

  assign in_ready_o = !full_i;
  assign acc        = in_valid_i && in_ready_o;
  assign mlen       = LenW'(m1_q[7:4]) + LenW'(MatchBias);
  assign clen       = (RemW'(mlen) > rem_q) ? LenW'(rem_q) : mlen;
  assign tl_dec     = tl_q - 4'd1;
  assign hdr_len    = rem_q | {in_byte_i, 16'd0};

  always_comb begin
    phase_d = phase_q;
    rem_d   = rem_q;
    flags_d = flags_q;
    tl_d    = tl_q;
    m1_d    = m1_q;
    push_o  = 1'b0;
    rem_tok = rem_q;
    cmd_o   = '{lit: 1'b1, data: in_byte_i, offset: '0, len: LenW'(1), eod: 1'b0};
    if (acc) begin
      if (start_of_stream_i) begin
        rem_d   = '0;
        flags_d = '0;
        tl_d    = '0;
        phase_d = PhHdr1;
      end else begin
        unique case (phase_q)
          PhHdr1: begin
            rem_d   = RemW'(in_byte_i);
            phase_d = PhHdr2;
          end
          PhHdr2: begin
            rem_d   = rem_q | {8'd0, in_byte_i, 8'd0};
            phase_d = PhHdr3;
          end
          PhHdr3: begin
            rem_d   = hdr_len;
            phase_d = (hdr_len == '0) ? PhIdle : PhFlags;
          end
          PhFlags: begin
            flags_d = in_byte_i;
            tl_d    = GroupTokens;
            phase_d = PhToken;
          end
          PhToken, PhMatch2: begin
            if (phase_q == PhToken && flags_q[7]) begin
              m1_d    = in_byte_i;
              phase_d = PhMatch2;
            end else begin
              if (phase_q == PhMatch2) begin
                cmd_o.lit    = 1'b0;
                cmd_o.offset = DistW'({m1_q[3:0], in_byte_i}) + DistW'(1);
                cmd_o.len    = clen;
                rem_tok      = rem_q - RemW'(clen);
              end else begin
                rem_tok = rem_q - RemW'(1);
              end
              cmd_o.eod = (rem_tok == '0);
              push_o    = 1'b1;
              rem_d     = rem_tok;
              flags_d   = {flags_q[6:0], 1'b0};
              tl_d      = tl_dec;
              if (rem_tok == '0) begin
                phase_d = PhIdle;
              end else if (tl_dec == 4'd0) begin
                phase_d = PhFlags;
              end else begin
                phase_d = PhToken;
              end
            end
          end
          default: phase_d = PhIdle;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      rem_q   <= '0;
      flags_q <= '0;
      tl_q    <= '0;
      m1_q    <= '0;
    end else begin
      phase_q <= phase_d;
      rem_q   <= rem_d;
      flags_q <= flags_d;
      tl_q    <= tl_d;
      m1_q    <= m1_d;
    end
  end

endmodule

`default_nettype wire

[design/lzwd_cmd_fifo.sv]
// Short command queue between the parser and the copy engine.
// Depends on lzwd_pkg.
`default_nettype none

module lzwd_cmd_fifo
  import lzwd_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t cmd_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      empty_o,
  output cmd_t      head_o
);

  localparam int unsigned PtrW = $clog2(CmdDepth);
  localparam int unsigned CntW = $clog2(CmdDepth + 1);

  cmd_t            mem_q [CmdDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(CmdDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + PtrW'(1);
      end
      cnt_q <= cnt_q + CntW'(push_i) - CntW'(pop_i);
    end
  end

endmodule

`default_nettype wire

[design/lzwd_back.sv]
// Copy engine: runs literal and match commands against the history ring.
// Depends on lzwd_pkg; holds the ring memory and the output register.
`default_nettype none

module lzwd_back
  import lzwd_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = WindowDepth
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       empty_i,
  input  wire cmd_t       head_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            last_of_run_o,
  output logic            end_of_data_o
);

  localparam int unsigned AW = $clog2(WINDOW_DEPTH);

  logic [7:0]      ring [WINDOW_DEPTH];
  logic [7:0]      rdata_q;

  cmd_t            cmd_q;
  logic            act_q;
  logic [LenW-1:0] cnt_q;
  logic [AW-1:0]   wp_q;
  logic            full_q;

  logic            p_valid_q;
  logic            p_lit_q, p_fwd_q, p_known_q, p_last_q, p_eod_q;
  logic [7:0]      p_lit_byte_q, p_fwd_byte_q;

  logic            out_valid_q;
  logic [7:0]      out_byte_q;
  logic            out_last_q, out_eod_q;

  logic            adv, issue, fin, tail;
  logic [AW-1:0]   src;
  logic [7:0]      w_byte;

  assign adv   = p_valid_q && (!out_valid_q || out_ready_i);
  assign issue = act_q && (!p_valid_q || adv);
  assign tail  = (cnt_q == LenW'(1));
  assign fin   = issue && tail;
  assign pop_o = !empty_i && (!act_q || fin);
  assign src   = wp_q + AW'(p_valid_q) - AW'(cmd_q.offset);

  always_comb begin
    if (p_lit_q) begin
      w_byte = p_lit_byte_q;
    end else if (p_fwd_q) begin
      w_byte = p_fwd_byte_q;
    end else if (p_known_q) begin
      w_byte = rdata_q;
    end else begin
      w_byte = 8'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ring[wp_q] <= w_byte;
    end
    if (issue) begin
      rdata_q <= ring[src];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q <= head_i;
    end
    if (issue) begin
      p_lit_q      <= cmd_q.lit;
      p_lit_byte_q <= cmd_q.data;
      p_fwd_q      <= adv && (src == wp_q);
      p_fwd_byte_q <= w_byte;
      p_known_q    <= full_q || (src < wp_q);
      p_last_q     <= tail;
      p_eod_q      <= tail && cmd_q.eod;
    end
    if (adv) begin
      out_byte_q <= w_byte;
      out_last_q <= p_last_q;
      out_eod_q  <= p_eod_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q       <= 1'b0;
      cnt_q       <= '0;
      wp_q        <= '0;
      full_q      <= 1'b0;
      p_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        act_q <= 1'b1;
        cnt_q <= head_i.len;
      end else if (fin) begin
        act_q <= 1'b0;
      end else if (issue) begin
        cnt_q <= cnt_q - LenW'(1);
      end
      if (issue) begin
        p_valid_q <= 1'b1;
      end else if (adv) begin
        p_valid_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
        wp_q        <= wp_q + AW'(1);
        if (&wp_q) begin
          full_q <= 1'b1;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign last_of_run_o = out_last_q;
  assign end_of_data_o = out_eod_q;

endmodule

`default_nettype wire

[design/lz77_window_decompressor_top.sv]
// LZSS window decompressor, top level: parser, command queue, copy engine.
// Path to an output byte: command queue, command register, read stage, output register.
// Throughput: one compressed byte per cycle while the four-entry queue has room;
// the copy engine emits one output byte per cycle while it has commands and out_ready_i is high.
// Reset clears all control state; ring entries never written since reset read as zero,
// tracked by the write pointer and a wrap flag, so no clearing pass is needed.
`default_nettype none

module lz77_window_decompressor_top
  import lzwd_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = WindowDepth
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       start_of_stream_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            last_of_run_o,
  output logic            end_of_data_o
);

  logic push, full, pop, empty;
  cmd_t cmd, head;

  lzwd_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .in_byte_i         (in_byte_i),
    .start_of_stream_i (start_of_stream_i),
    .full_i            (full),
    .push_o            (push),
    .cmd_o             (cmd)
  );

  lzwd_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head)
  );

  lzwd_back #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o),
    .end_of_data_o (end_of_data_o)
  );

endmodule

`default_nettype wire
